[hdl/spq_pkg.sv]
// Package: depth, widths, entry and control types for the sorted priority queue.
package spq_pkg;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	typedef struct packed {
		logic        [15:0] id;
		logic signed [15:0] prio;
	} entry_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DUMP   = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STS_ACCEPTED = 2'd0,
		STS_DROPPED  = 2'd1,
		STS_DUMP     = 2'd2,
		STS_EMPTY    = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DUMP = 1'b1
	} state_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic pop;
	} chain_ctl_t;

endpackage

[hdl/spq_in_if.sv]
// Interface: input channel of the sorted priority queue.
interface spq_in_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic        [15:0] entry_id;
	logic signed [15:0] entry_priority;

	modport source (output valid, opcode, entry_id, entry_priority, input ready);
	modport sink   (input valid, opcode, entry_id, entry_priority, output ready);
endinterface

[hdl/spq_out_if.sv]
// Interface: result channel of the sorted priority queue.
interface spq_out_if;
	logic               valid;
	logic               ready;
	logic        [15:0] out_id;
	logic signed [15:0] out_priority;
	logic         [1:0] status;
	logic               last;

	modport source (output valid, out_id, out_priority, status, last, input ready);
	modport sink   (input valid, out_id, out_priority, status, last, output ready);
endinterface

[hdl/sorted_priority_queue.sv]
// Top level: sorted insertion priority queue built as a chain of compare-and-shift cells.
// Insert: one beat in, one status beat out in the next cycle; one insert per cycle when
//   the result side keeps up, since every cell compares against the new entry at once.
// Dump: a beat per entry from the head cell, one per cycle unless stalled; empty gives one.
// Reset (arst_n low, asynchronous) empties the queue and the result register; entry
//   storage is not cleared and no clearing pass is needed.
module sorted_priority_queue (
	input  logic clk,
	input  logic arst_n,
	spq_in_if.sink    in_ch,
	spq_out_if.source out_ch
);
	import spq_pkg::*;

	// Control state.
	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	// Result register.
	logic        out_valid_q;
	logic        out_valid_d;
	logic [15:0] out_id_q;
	logic [15:0] out_prio_q;
	status_t     out_status_q;
	logic        out_last_q;
	logic        load;
	logic [15:0] load_id;
	logic [15:0] load_prio;
	status_t     load_status;
	logic        load_last;

	logic       out_free;
	logic       accept;
	logic       full;
	logic       empty;
	chain_ctl_t ctl;
	entry_t     new_entry;
	entry_t     head;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	// The result register frees up when empty or when its beat leaves this cycle.
	assign out_free = !out_valid_q || out_ch.ready;

	assign in_ch.ready = (state_q == ST_IDLE) && out_free;
	assign accept      = in_ch.valid && in_ch.ready;

	assign new_entry.id   = in_ch.entry_id;
	assign new_entry.prio = in_ch.entry_priority;

	spq_chain u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.new_entry (new_entry),
		.count     (count_q),
		.head      (head)
	);

	// Next state, chain command and the beat to load into the result register.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		ctl         = '0;
		load        = 1'b0;
		load_id     = '0;
		load_prio   = '0;
		load_status = STS_ACCEPTED;
		load_last   = 1'b1;
		out_valid_d = out_valid_q && !out_ch.ready;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					load = 1'b1;
					if (opcode_t'(in_ch.opcode) == OP_INSERT) begin
						if (full) begin
							// Drop the entry; queue holds as is.
							load_status = STS_DROPPED;
						end else begin
							ctl.ins = 1'b1;
							count_d = count_q + CNT_W'(1);
						end
					end else if (empty) begin
						load_status = STS_EMPTY;
					end else begin
						// Nothing emitted yet; the dump pops from the ST_DUMP state on.
						load    = 1'b0;
						state_d = ST_DUMP;
					end
				end
			end
			ST_DUMP: begin
				if (out_free) begin
					// Pop the head cell; every cell advances one place toward the head.
					ctl.pop     = 1'b1;
					load        = 1'b1;
					load_id     = head.id;
					load_prio   = head.prio;
					load_status = STS_DUMP;
					load_last   = count_q == CNT_W'(1);
					count_d     = count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (load) begin
			out_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Result payload: hold until the next load.
	always_ff @(posedge clk) begin
		if (load) begin
			out_id_q     <= load_id;
			out_prio_q   <= load_prio;
			out_status_q <= load_status;
			out_last_q   <= load_last;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_id       = out_id_q;
	assign out_ch.out_priority = out_prio_q;
	assign out_ch.status       = out_status_q;
	assign out_ch.last         = out_last_q;

endmodule

[hdl/spq_cell.sv]
// One queue cell: holds an entry, takes the new entry, its left or right neighbor.
module spq_cell (
	input  logic           clk,
	input  spq_pkg::chain_ctl_t ctl,
	input  spq_pkg::entry_t     new_entry,
	input  spq_pkg::entry_t     left_entry,
	input  logic           left_shift,
	input  logic           left_occ,
	input  spq_pkg::entry_t     right_entry,
	input  logic           occ,
	output spq_pkg::entry_t     entry,
	output logic           shift
);
	import spq_pkg::*;

	entry_t entry_q;
	logic   take_left;
	logic   take_new;

	// Stored entry moves right when the new one sorts strictly ahead of it.
	assign shift     = occ && (new_entry.prio < entry_q.prio);
	assign take_left = ctl.ins && left_shift;
	assign take_new  = ctl.ins && !left_shift && (shift || (!occ && left_occ));
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		priority if (ctl.pop) begin
			entry_q <= right_entry;
		end else if (take_left) begin
			entry_q <= left_entry;
		end else if (take_new) begin
			entry_q <= new_entry;
		end
	end

endmodule

[hdl/spq_chain.sv]
// Row of queue cells kept in ascending priority order.
module spq_chain (
	input  logic                      clk,
	input  spq_pkg::chain_ctl_t       ctl,
	input  spq_pkg::entry_t           new_entry,
	input  logic [spq_pkg::CNT_W-1:0] count,
	output spq_pkg::entry_t           head
);
	import spq_pkg::*;

	entry_t           entries [DEPTH];
	logic [DEPTH-1:0] shifts;
	logic [DEPTH-1:0] occs;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t l_entry;
		entry_t r_entry;
		logic   l_shift;
		logic   l_occ;

		assign occs[i] = count > CNT_W'(i);

		if (i == 0) begin : g_first
			assign l_entry = new_entry;
			assign l_shift = 1'b0;
			assign l_occ   = 1'b1;
		end else begin : g_inner
			assign l_entry = entries[i-1];
			assign l_shift = shifts[i-1];
			assign l_occ   = occs[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_entry = entries[i];
		end else begin : g_mid
			assign r_entry = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (l_entry),
			.left_shift  (l_shift),
			.left_occ    (l_occ),
			.right_entry (r_entry),
			.occ         (occs[i]),
			.entry       (entries[i]),
			.shift       (shifts[i])
		);
	end

	assign head = entries[0];

endmodule

[dv/tb_sorted_priority_queue.sv]
// Testbench for the sorted priority queue: directed table, random insert/dump bursts, shadow-model checks.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
	import spq_pkg::*;

	// Run limits, sized from the slowest legal run (every beat behind a long stall) and then
	// padded several times over.
	localparam int unsigned CYCLE_LIMIT = 5_000_000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned TOTAL_ITEMS = 270;
	localparam int unsigned REPORT_MAX  = 10;
	localparam int unsigned TAIL_CYCLES = 20;

	// Shape of the random priorities: anything, a narrow band that forces ties, or the corners.
	typedef enum int {
		PRIO_ANY,
		PRIO_TIES,
		PRIO_CORNER
	} prio_mode_t;

	// One beat on the result channel.
	typedef struct packed {
		logic        [15:0] id;
		logic signed [15:0] prio;
		status_t            status;
		logic               last;
	} result_beat_t;

	// One row of the directed table. When typed is set the row carries its own single-beat
	// answer; otherwise the shadow queue supplies the answer.
	typedef struct packed {
		opcode_t            op;
		logic        [15:0] id;
		logic signed [15:0] prio;
		logic               typed;
		status_t            exp_status;
		logic        [15:0] exp_id;
		logic signed [15:0] exp_prio;
	} stim_row_t;

	logic clk;
	logic arst_n;

	spq_in_if  in_ch ();
	spq_out_if out_ch ();

	sorted_priority_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Shadow of the stored entries, kept in service order, and the beats it predicts.
	entry_t       shadow_queue [$];
	result_beat_t shadow_beats [$];
	// Beats still owed by the block, oldest first.
	result_beat_t awaited_beats [$];

	int   bad_beats;
	int   items_sent;
	logic sender_calm;
	logic sink_calm;
	logic hold_req;

	// Directed table: empty dump after reset, the id and priority extremes, ties at the
	// low end, the middle and the high end (arrival order must survive), a single-entry dump,
	// a descending run that lands every insert at the head, and a dump whose ignored fields
	// are all ones.
	stim_row_t directed_rows [20] = '{
		'{OP_DUMP,   16'h0000, 16'sh0000, 1'b1, STS_EMPTY,    16'h0000, 16'sh0000},
		'{OP_INSERT, 16'hFFFF, 16'sh7FFF, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_INSERT, 16'h0000, 16'sh8000, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_INSERT, 16'h1234, 16'sh0000, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_INSERT, 16'h1235, 16'sh0000, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_INSERT, 16'h1236, 16'shFFFF, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_INSERT, 16'h1237, 16'sh0000, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_INSERT, 16'hAAAA, 16'sh7FFF, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_INSERT, 16'h5555, 16'sh8000, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_DUMP,   16'h5A5A, 16'sh1234, 1'b0, STS_DUMP,     16'h0000, 16'sh0000},
		'{OP_DUMP,   16'h0000, 16'sh0000, 1'b1, STS_EMPTY,    16'h0000, 16'sh0000},
		'{OP_INSERT, 16'h8001, 16'sh0001, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_DUMP,   16'hFFFF, 16'sh8000, 1'b1, STS_DUMP,     16'h8001, 16'sh0001},
		'{OP_INSERT, 16'h0101, 16'sh0005, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_INSERT, 16'h0102, 16'sh0004, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_INSERT, 16'h0103, 16'sh0003, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_INSERT, 16'h0104, 16'sh0002, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_INSERT, 16'h0105, 16'sh0001, 1'b1, STS_ACCEPTED, 16'h0000, 16'sh0000},
		'{OP_DUMP,   16'h0000, 16'sh0000, 1'b0, STS_DUMP,     16'h0000, 16'sh0000},
		'{OP_DUMP,   16'hFFFF, 16'shFFFF, 1'b1, STS_EMPTY,    16'h0000, 16'sh0000}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one command to the shadow queue and leave the beats it causes in shadow_beats.
	function automatic void order_shadow(input opcode_t op, input logic [15:0] id,
			input logic signed [15:0] prio);
		int pos;
		shadow_beats.delete();
		if (op == OP_INSERT) begin
			if (shadow_queue.size() >= DEPTH) begin
				// Full: drop the entry, leave the queue alone.
				shadow_beats.push_back('{16'h0000, 16'sh0000, STS_DROPPED, 1'b1});
			end else begin
				// Skip every entry at or below the new priority so ties keep arrival order.
				pos = 0;
				while (pos < shadow_queue.size() && shadow_queue[pos].prio <= prio)
					pos++;
				shadow_queue.insert(pos, '{id, prio});
				shadow_beats.push_back('{16'h0000, 16'sh0000, STS_ACCEPTED, 1'b1});
			end
		end else if (shadow_queue.size() == 0) begin
			shadow_beats.push_back('{16'h0000, 16'sh0000, STS_EMPTY, 1'b1});
		end else begin
			// Emit head to tail, flag the tail, then empty.
			foreach (shadow_queue[i])
				shadow_beats.push_back('{shadow_queue[i].id, shadow_queue[i].prio, STS_DUMP,
					i == shadow_queue.size() - 1});
			shadow_queue.delete();
		end
	endfunction

	function automatic logic signed [15:0] pick_priority(input prio_mode_t mode);
		int band;
		case (mode)
			PRIO_TIES: begin
				band = int'($urandom_range(0, 6)) - 3;
				return band[15:0];
			end
			PRIO_CORNER: begin
				case ($urandom_range(0, 5))
					0:       return 16'sh8000;
					1:       return 16'sh8001;
					2:       return 16'shFFFF;
					3:       return 16'sh0000;
					4:       return 16'sh7FFE;
					default: return 16'sh7FFF;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one beat, hold it until the block takes it, then book the beats it owes.
	// Called and returning at a rising edge.
	task automatic send_item(input opcode_t op, input logic [15:0] id,
			input logic signed [15:0] prio, input logic typed, input result_beat_t typed_beat);
		int gap;
		int pick;
		gap = 0;
		if (!sender_calm) begin
			// Mostly back-to-back or short gaps, now and then a long one.
			pick = $urandom_range(0, 99);
			if (pick < 55)
				gap = 0;
			else if (pick < 85)
				gap = $urandom_range(1, 3);
			else if (pick < 97)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.opcode         <= op;
		in_ch.entry_id       <= id;
		in_ch.entry_priority <= prio;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		order_shadow(op, id, prio);
		if (typed)
			awaited_beats.push_back(typed_beat);
		else
			foreach (shadow_beats[i])
				awaited_beats.push_back(shadow_beats[i]);
		items_sent++;
	endtask

	task automatic insert_burst(input int count, input prio_mode_t mode);
		repeat (count)
			send_item(OP_INSERT, 16'($urandom), pick_priority(mode), 1'b0, '0);
	endtask

	// Dump with random junk in the ignored fields.
	task automatic dump_queue();
		send_item(OP_DUMP, 16'($urandom), 16'($urandom), 1'b0, '0);
	endtask

	// Stimulus: reset, directed table, backpressure fill, corner fill, then random bursts.
	initial begin
		result_beat_t row_beat;
		logic         calm;
		int           count;
		arst_n               = 1'b0;
		in_ch.valid          = 1'b0;
		in_ch.opcode         = OP_INSERT;
		in_ch.entry_id       = 16'h0000;
		in_ch.entry_priority = 16'sh0000;
		sender_calm          = 1'b0;
		sink_calm            = 1'b0;
		hold_req             = 1'b0;
		bad_beats            = 0;
		items_sent           = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row_beat = '{directed_rows[i].exp_id, directed_rows[i].exp_prio,
				directed_rows[i].exp_status, 1'b1};
			send_item(directed_rows[i].op, directed_rows[i].id, directed_rows[i].prio,
				directed_rows[i].typed, row_beat);
		end

		// Hold the result side off for a long stretch while inserts keep coming with no
		// gaps: the block must stall its input, then once released fill, hit full and drop.
		sender_calm = 1'b1;
		hold_req <= ~hold_req;
		insert_burst(40, PRIO_TIES);
		insert_burst(30, PRIO_ANY);
		dump_queue();
		sender_calm = 1'b0;

		// Fill past full again, this time with corner priorities and random gaps.
		insert_burst(66, PRIO_CORNER);
		dump_queue();

		// Random bursts: mostly short insert runs closed by a dump, now and then a long run,
		// sometimes a second dump that lands on an empty queue.
		while (items_sent < TOTAL_ITEMS) begin
			calm        = ($urandom_range(0, 3) == 0);
			sender_calm = calm;
			sink_calm  <= calm;
			if ($urandom_range(0, 7) == 0)
				count = $urandom_range(11, 30);
			else
				count = $urandom_range(0, 10);
			insert_burst(count, prio_mode_t'($urandom_range(0, 2)));
			dump_queue();
			if ($urandom_range(0, 5) == 0)
				dump_queue();
		end

		// Drop valid, drain what is owed, then keep watching for stray beats before the verdict.
		sender_calm  = 1'b0;
		sink_calm   <= 1'b0;
		in_ch.valid <= 1'b0;
		while (awaited_beats.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_beats == 0 && awaited_beats.size() == 0) begin
			$display("tb_sorted_priority_queue OK");
		end else begin
			$display("tb_sorted_priority_queue NOT OK");
		end
		$finish;
	end

	// Result-side ready: alternating ready runs and stalls, always ready in calm stretches,
	// and one long hold-off counted here whenever the stimulus flips hold_req.
	initial begin
		int   hold_left;
		int   run_left;
		int   pick;
		logic run_ready;
		logic hold_seen;
		hold_left    = 0;
		run_left     = 0;
		run_ready    = 1'b0;
		hold_seen    = 1'b0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (sink_calm) begin
				out_ch.ready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					run_ready = !run_ready;
					if (run_ready) begin
						run_left = $urandom_range(1, 20);
					end else begin
						pick = $urandom_range(0, 99);
						if (pick < 70)
							run_left = $urandom_range(1, 2);
						else if (pick < 95)
							run_left = $urandom_range(3, 8);
						else
							run_left = $urandom_range(20, 50);
					end
				end
				run_left--;
				out_ch.ready <= run_ready;
			end
		end
	end

	// Compare every accepted result beat with the oldest one owed.
	always @(posedge clk) begin
		result_beat_t got;
		result_beat_t want;
		if (out_ch.valid && out_ch.ready) begin
			got = '{out_ch.out_id, out_ch.out_priority, status_t'(out_ch.status), out_ch.last};
			if (awaited_beats.size() == 0) begin
				if (bad_beats < REPORT_MAX)
					$display("%0t: unexpected beat id %h prio %0d status %0d last %b",
						$realtime, got.id, got.prio, got.status, got.last);
				bad_beats++;
			end else begin
				want = awaited_beats.pop_front();
				if (got !== want) begin
					if (bad_beats < REPORT_MAX) begin
						$write("%0t: beat mismatch, expected id %h prio %0d status %0d last %b, ",
							$realtime, want.id, want.prio, want.status, want.last);
						$display("got id %h prio %0d status %0d last %b",
							got.id, got.prio, got.status, got.last);
					end
					bad_beats++;
				end
			end
		end
	end

	// Watchdog: end a hung run.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_sorted_priority_queue NOT OK");
		$finish;
	end

endmodule
